FILE: src/fwm_pkg.sv
// fwm_pkg: shared types, constants and helpers for the fuzzy word matcher
// used by fwm_cell and fuzzy_word_matcher; no dependencies
`default_nettype none

package fwm_pkg;

  localparam int CHAR_W = 16;
  localparam int LEN_W  = 6;
  localparam int GAP_W  = 6;
  localparam int TYPO_W = 2;
  localparam int CFG_W  = 6;

  localparam int MAX_TERM_DEF     = 32;
  localparam int LONGEST_WORD_DEF = 63;
  localparam int POS_BITS_DEF     = 10;

  localparam logic OP_TERM = 1'b0;
  localparam logic OP_WORD = 1'b1;

  localparam logic REG_GAPS  = 1'b0;
  localparam logic REG_TYPOS = 1'b1;

  typedef enum logic [1:0] {
    Q_NONE  = 2'd0,
    Q_EXACT = 2'd1,
    Q_FUZZY = 2'd2
  } quality_t;

  // token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;      // word character
    logic [CHAR_W-1:0] prev;    // previous word character
    logic              pos1;    // word position at least one
    logic [LEN_W-1:0]  n;       // term length
    logic [LEN_W-1:0]  ocnt;    // ordered match count before this character
    logic [1:0]        fresh;   // new distance of left neighbor
    logic [1:0]        dold;    // old distance of left neighbor
    logic [1:0]        oleft;   // older distance of left neighbor
    logic [1:0]        o2;      // older distance two cells back
    logic [CHAR_W-1:0] tl;      // term character of left neighbor
    logic              tl_ok;   // left neighbor holds a term character
    logic              hl;      // old prefix hit of left neighbor
    logic              ohit;    // ordered match advanced
    logic              hitn;    // full-term prefix hit
    logic [1:0]        dn;      // new distance at row n
  } fwm_tok_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [LEN_W-1:0]  wr_idx;
    logic [CHAR_W-1:0] wr_char;
  } fwm_ctl_t;

  function automatic logic [1:0] inc3(input logic [1:0] v);
    inc3 = (v == 2'd3) ? 2'd3 : v + 2'd1;
  endfunction

  function automatic logic [1:0] add3(input logic [1:0] v, input logic b);
    add3 = b ? inc3(v) : v;
  endfunction

  function automatic logic [1:0] min2(input logic [1:0] a, input logic [1:0] b);
    min2 = (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: src/fuzzy_word_matcher.sv
// fuzzy_word_matcher: top level; term loading, word sequencing, cell row and result
// register; depends on fwm_pkg and fwm_cell
// a term character within the row's capacity is written into its cell as it is accepted;
// a word character walks the row of MAX_TERM cells one cell per cycle, and no new request
// is taken until its token has left the row and, for a final character, the result register is free
// synchronous active-high reset empties the term, clears word state and both registers
`default_nettype none

module fuzzy_word_matcher import fwm_pkg::*; #(
  parameter int MAX_TERM     = MAX_TERM_DEF,
  parameter int LONGEST_WORD = LONGEST_WORD_DEF,
  parameter int POS_BITS     = POS_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration writes
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              opcode,
  input  wire logic [CHAR_W-1:0] character,
  input  wire logic              final_char,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             quality
);

  localparam logic [LEN_W-1:0]    MAX_TERM_L = LEN_W'(MAX_TERM);
  localparam logic [POS_BITS-1:0] POS_MAX    = {POS_BITS{1'b1}};
  localparam logic [POS_BITS:0]   LONGEST_L  = (POS_BITS + 1)'(LONGEST_WORD);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [GAP_W-1:0]  gaps_allowed;
  logic [TYPO_W-1:0] typos_allowed;

  // term bookkeeping (characters live in the cells)
  logic [LEN_W-1:0] term_length;
  logic             term_complete;

  // word state kept in the sequencer
  logic                exact_seen;
  logic [CHAR_W-1:0]   previous_char;
  logic [LEN_W-1:0]    ordered_count;
  logic [POS_BITS-1:0] ordered_last_pos;
  logic                ordered_dead;
  logic [POS_BITS-1:0] word_position;

  // word character in flight
  logic              cur_fin;
  logic [CHAR_W-1:0] cur_char;

  // what the token brought back from the end of the row
  logic       ex_ohit;
  logic       ex_hitn;
  logic [1:0] ex_dn;

  // token launched into the row, and the row itself
  fwm_tok_t launch;
  fwm_tok_t tok [MAX_TERM+1];
  fwm_ctl_t ctl;

  logic accept;
  logic term_req;
  logic word_req;
  logic out_free;
  logic finish_word;

  // term write address: a term character after a complete term restarts at zero
  logic [LEN_W-1:0] wr_base;

  // finishing arithmetic
  logic                exact_n;
  logic [LEN_W-1:0]    ocount_n;
  logic [POS_BITS-1:0] olast_n;
  logic                odead_n;
  logic [POS_BITS:0]   last_plus;
  logic [POS_BITS:0]   n_ext;
  logic [POS_BITS:0]   gap;
  logic [POS_BITS:0]   word_len;
  logic [POS_BITS:0]   len_diff;
  logic [1:0]          typo_lim;
  logic                fuzzy_order;
  logic                fuzzy_typo;
  quality_t            q_next;

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign term_req = accept && (opcode == OP_TERM);
  assign word_req = accept && (opcode == OP_WORD);
  assign out_free = !out_valid || out_ready;
  // a final character waits here until the result register is free
  assign finish_word = (state == S_FINISH) && (!cur_fin || out_free);
  assign wr_base = term_complete ? '0 : term_length;
  assign tok[0]  = launch;

  always_comb begin
    ctl.wr_en   = term_req && (wr_base < MAX_TERM_L);
    ctl.wr_idx  = wr_base;
    ctl.wr_char = character;
    ctl.clear   = term_req || (finish_word && cur_fin);
  end

  // saturated distances of row zero
  function automatic logic [1:0] sat_pos(input logic [POS_BITS-1:0] p);
    sat_pos = (p >= POS_BITS'(3)) ? 2'd3 : p[1:0];
  endfunction

  // cell row
  genvar gi;
  generate
    for (gi = 1; gi <= MAX_TERM; gi++) begin : g_cell
      fwm_cell #(.IDX(gi)) u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl),
        .tin  (tok[gi-1]),
        .tout (tok[gi])
      );
    end
  endgenerate

  // result of a finished word character
  always_comb begin
    exact_n  = exact_seen || ex_hitn;
    ocount_n = ordered_count;
    olast_n  = ordered_last_pos;
    odead_n  = ordered_dead;
    if (word_position == '0) begin
      // first letter must be the term's first letter
      if (term_length == '0 || !ex_ohit) begin
        odead_n = 1'b1;
      end else begin
        ocount_n = LEN_W'(1);
        olast_n  = '0;
      end
    end else if (!ordered_dead && ex_ohit) begin
      ocount_n = ordered_count + LEN_W'(1);
      olast_n  = word_position;
    end

    n_ext     = (POS_BITS + 1)'(term_length);
    last_plus = {1'b0, olast_n} + (POS_BITS + 1)'(1);
    gap       = (last_plus >= n_ext) ? last_plus - n_ext : '0;
    fuzzy_order = !odead_n && (ocount_n == term_length) &&
                  (gap <= (POS_BITS + 1)'(gaps_allowed));

    word_len = {1'b0, word_position} + (POS_BITS + 1)'(1);
    len_diff = (word_len > n_ext) ? word_len - n_ext : n_ext - word_len;
    typo_lim = (typos_allowed > 2'd2) ? 2'd2 : typos_allowed;
    fuzzy_typo = (typo_lim != 2'd0) && (word_len <= LONGEST_L) &&
                 (len_diff <= (POS_BITS + 1)'(typo_lim)) && (ex_dn <= typo_lim);

    q_next = Q_NONE;
    if (term_complete && term_length != '0) begin
      if (exact_n) begin
        q_next = Q_EXACT;
      end else if (fuzzy_order || fuzzy_typo) begin
        q_next = Q_FUZZY;
      end
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      gaps_allowed     <= '0;
      typos_allowed    <= '0;
      term_length      <= '0;
      term_complete    <= 1'b0;
      exact_seen       <= 1'b0;
      previous_char    <= '0;
      ordered_count    <= '0;
      ordered_last_pos <= '0;
      ordered_dead     <= 1'b0;
      word_position    <= '0;
      out_valid        <= 1'b0;
      quality          <= Q_NONE;
      launch           <= '0;
      cur_fin          <= 1'b0;
      cur_char         <= '0;
      ex_ohit          <= 1'b0;
      ex_hitn          <= 1'b0;
      ex_dn            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAPS:  gaps_allowed  <= cfg_data[GAP_W-1:0];
          REG_TYPOS: typos_allowed <= cfg_data[TYPO_W-1:0];
          default:   gaps_allowed  <= gaps_allowed;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      launch.valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (term_req) begin
            if (wr_base < MAX_TERM_L) begin
              term_length <= wr_base + LEN_W'(1);
            end else begin
              term_length <= wr_base;
            end
            term_complete    <= final_char;
            // any term character abandons the word in progress
            exact_seen       <= 1'b0;
            previous_char    <= '0;
            ordered_count    <= '0;
            ordered_last_pos <= '0;
            ordered_dead     <= 1'b0;
            word_position    <= '0;
          end else if (word_req) begin
            // launch a token into the row, carrying row zero of the matrix
            launch.valid <= 1'b1;
            launch.ch    <= character;
            launch.prev  <= previous_char;
            launch.pos1  <= (word_position != '0);
            launch.n     <= term_length;
            launch.ocnt  <= (word_position == '0) ? '0 : ordered_count;
            launch.fresh <= (word_position >= POS_BITS'(2)) ? 2'd3
                            : word_position[1:0] + 2'd1;
            launch.dold  <= sat_pos(word_position);
            launch.oleft <= (word_position == '0) ? 2'd0
                            : sat_pos(word_position - POS_BITS'(1));
            launch.o2    <= '0;
            launch.tl    <= '0;
            launch.tl_ok <= 1'b0;
            launch.hl    <= 1'b1;
            launch.ohit  <= 1'b0;
            launch.hitn  <= 1'b0;
            launch.dn    <= '0;
            cur_fin      <= final_char;
            cur_char     <= character;
            state        <= S_RUN;
          end
        end

        S_RUN: begin
          if (tok[MAX_TERM].valid) begin
            ex_ohit <= tok[MAX_TERM].ohit;
            ex_hitn <= tok[MAX_TERM].hitn;
            ex_dn   <= tok[MAX_TERM].dn;
            state   <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (finish_word) begin
            state <= S_IDLE;
            if (cur_fin) begin
              out_valid        <= 1'b1;
              quality          <= q_next;
              exact_seen       <= 1'b0;
              previous_char    <= '0;
              ordered_count    <= '0;
              ordered_last_pos <= '0;
              ordered_dead     <= 1'b0;
              word_position    <= '0;
            end else begin
              exact_seen       <= exact_n;
              ordered_count    <= ocount_n;
              ordered_last_pos <= olast_n;
              ordered_dead     <= odead_n;
              previous_char    <= cur_char;
              if (word_position != POS_MAX) begin
                word_position <= word_position + POS_BITS'(1);
              end
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the token leaves the row only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    tok[MAX_TERM].valid |-> state == S_RUN)
    else $error("token left the cell row outside of a word step");

  // a result is only ever raised when a word step finishes
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH && $past(cur_fin))
    else $error("result raised without a finished final character");

  // an accepted word character launches exactly one token
  assert property (@(posedge clk) disable iff (rst)
    word_req |=> tok[0].valid && state == S_RUN)
    else $error("word character accepted without a token");

  // stored term length never passes the cell count
  assert property (@(posedge clk) disable iff (rst)
    term_length <= MAX_TERM_L)
    else $error("term length beyond the cell row");

endmodule

`default_nettype wire

FILE: src/fwm_cell.sv
// fwm_cell: one term position; holds its term character, distance pair and prefix hit
// depends on fwm_pkg
`default_nettype none

module fwm_cell import fwm_pkg::*; #(
  parameter int IDX = 1
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire fwm_ctl_t ctl,
  input  wire fwm_tok_t tin,
  output fwm_tok_t      tout
);

  localparam logic [LEN_W-1:0] IDX_L  = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] IDX_M1 = LEN_W'(IDX - 1);
  localparam logic [1:0]       INIT   = (IDX > 3) ? 2'd3 : 2'(IDX);

  logic [CHAR_W-1:0] term_char;
  logic [1:0]        dcur;
  logic [1:0]        older;
  logic              hit;

  logic       match;
  logic [1:0] dist_next;
  logic       hit_next;
  logic       at_n;
  fwm_tok_t   tnext;

  always_comb begin
    match     = (term_char == tin.ch);
    dist_next = min2(min2(inc3(dcur), inc3(tin.fresh)), add3(tin.dold, !match));
    // adjacent swap
    if (tin.tl_ok && tin.pos1 && term_char == tin.prev && tin.tl == tin.ch) begin
      dist_next = min2(dist_next, inc3(tin.o2));
    end
    hit_next = tin.hl && match;
    at_n     = (IDX_L == tin.n);

    tnext       = tin;
    tnext.fresh = dist_next;
    tnext.dold  = dcur;
    tnext.oleft = older;
    tnext.o2    = tin.oleft;
    tnext.tl    = term_char;
    tnext.tl_ok = 1'b1;
    tnext.hl    = hit;
    if (tin.ocnt == IDX_M1 && IDX_L <= tin.n && match) begin
      tnext.ohit = 1'b1;
    end
    if (at_n) begin
      tnext.hitn = tin.hitn | hit_next;
      tnext.dn   = dist_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_idx == IDX_M1) begin
      term_char <= ctl.wr_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      dcur  <= INIT;
      older <= INIT;
      hit   <= 1'b0;
    end else if (tin.valid) begin
      dcur  <= dist_next;
      older <= dcur;
      hit   <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout <= '0;
    end else begin
      tout <= tnext;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/fuzzy_word_matcher_tb.sv
// fuzzy_word_matcher_tb: self-checking bench for fuzzy_word_matcher, with its own scoring
// model, queue-fed request driver, result monitor and a stall watchdog
// depends on fwm_pkg and the fuzzy_word_matcher rtl only
module fuzzy_word_matcher_tb import fwm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_MAX       = (1 << POS_BITS_DEF) - 1;
  // room after draining for a word request still walking the cell row, with margin
  localparam int SETTLE_CYCLES = 2 * (MAX_TERM_DEF + 3);
  localparam int STALL_LIMIT   = 2000;
  localparam logic [CHAR_W-1:0] LETTER_BASE = 16'h0061;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } char_req_t;

  logic              clk;
  logic              rst        = 1'b1;
  logic              cfg_we     = 1'b0;
  logic              cfg_index  = REG_GAPS;
  logic [CFG_W-1:0]  cfg_data   = '0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic              opcode     = OP_TERM;
  logic [CHAR_W-1:0] character  = '0;
  logic              final_char = 1'b0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [1:0]        quality;

  // requests waiting to be driven, and the qualities the model says are on their way
  char_req_t pending[$];
  quality_t  quality_due[$];
  char_req_t on_wire;

  int reqs_queued   = 0;
  int reqs_taken    = 0;
  int results_seen  = 0;
  int exact_count   = 0;
  int fuzzy_count   = 0;
  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // scoring model state
  logic [CHAR_W-1:0] term_chars [MAX_TERM_DEF];
  int unsigned       term_len;
  bit                term_done;
  bit                prefix_hit [MAX_TERM_DEF];
  bit                exact_hit;
  logic [1:0]        dist_now [MAX_TERM_DEF+1];
  logic [1:0]        dist_old [MAX_TERM_DEF+1];
  logic [CHAR_W-1:0] last_char;
  int unsigned       order_cnt;
  int unsigned       order_pos;
  bit                order_dead;
  int unsigned       word_pos;
  logic [GAP_W-1:0]  gaps_cfg;
  logic [TYPO_W-1:0] typos_cfg;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  fuzzy_word_matcher i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .character  (character),
    .final_char (final_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .quality    (quality)
  );

  function automatic logic [1:0] sat3(input int unsigned v);
    return (v > 3) ? 2'd3 : v[1:0];
  endfunction

  function automatic logic [1:0] low2(input logic [1:0] a, input logic [1:0] b);
    return (a < b) ? a : b;
  endfunction

  // every word-side register back to its idle value; the term survives
  function automatic void clear_word_state();
    int i;
    for (i = 0; i < MAX_TERM_DEF; i++) prefix_hit[i] = 1'b0;
    for (i = 0; i <= MAX_TERM_DEF; i++) begin
      dist_now[i] = sat3(i);
      dist_old[i] = sat3(i);
    end
    exact_hit  = 1'b0;
    last_char  = '0;
    order_cnt  = 0;
    order_pos  = 0;
    order_dead = 1'b0;
    word_pos   = 0;
  endfunction

  // one accepted request through the model; a final word character yields a quality
  function automatic void score_char(input char_req_t r);
    logic [1:0]  col [MAX_TERM_DEF+1];
    logic [1:0]  d;
    int unsigned n, pos, m, lim, gap, diff, cost, i, k;
    bit          prior, fuzzy;
    quality_t    q;
    n = (term_len > MAX_TERM_DEF) ? MAX_TERM_DEF : term_len;
    if (r.op == OP_TERM) begin
      // a term character after a finished term starts a new one
      if (term_done) begin
        term_len  = 0;
        term_done = 1'b0;
      end
      // characters beyond the term capacity are dropped
      if (term_len < MAX_TERM_DEF) begin
        term_chars[term_len] = r.ch;
        term_len++;
      end
      if (r.fin) term_done = 1'b1;
      clear_word_state();
      return;
    end
    pos = word_pos;

    // next distance column, adjacent swaps counted as one edit, saturating at three
    col[0] = sat3(pos + 1);
    for (i = 1; i <= n; i++) begin
      cost = (term_chars[i-1] == r.ch) ? 0 : 1;
      d = low2(sat3(dist_now[i] + 1), sat3(col[i-1] + 1));
      d = low2(d, sat3(dist_now[i-1] + cost));
      if (i > 1 && pos >= 1 && term_chars[i-1] == last_char && term_chars[i-2] == r.ch)
        d = low2(d, sat3(dist_old[i-2] + 1));
      col[i] = d;
    end
    for (i = 0; i <= n; i++) begin
      dist_old[i] = dist_now[i];
      dist_now[i] = col[i];
    end

    // substring prefix hits, top row first so each reads the previous character's bit
    for (i = n; i > 0; i--) begin
      k = i - 1;
      prior = (k == 0) ? 1'b1 : prefix_hit[k-1];
      prefix_hit[k] = prior && (term_chars[k] == r.ch);
    end
    if (n > 0 && prefix_hit[n-1]) exact_hit = 1'b1;

    // greedy ordered letters; the word must open with the term's first letter
    if (pos == 0) begin
      if (n == 0 || r.ch != term_chars[0]) begin
        order_dead = 1'b1;
      end else begin
        order_cnt = 1;
        order_pos = 0;
      end
    end else if (!order_dead && order_cnt < n && r.ch == term_chars[order_cnt]) begin
      order_cnt++;
      order_pos = pos;
    end

    last_char = r.ch;
    if (word_pos < POS_MAX) word_pos++;
    if (!r.fin) return;

    q   = Q_NONE;
    m   = pos + 1;
    lim = (typos_cfg > 2) ? 2 : typos_cfg;
    if (term_done && n > 0) begin
      if (exact_hit) begin
        q = Q_EXACT;
      end else begin
        fuzzy = 1'b0;
        if (!order_dead && order_cnt == n) begin
          gap = (order_pos + 1 >= n) ? order_pos + 1 - n : 0;
          if (gap <= gaps_cfg) fuzzy = 1'b1;
        end
        if (!fuzzy && lim > 0 && m <= LONGEST_WORD_DEF) begin
          diff = (m > n) ? m - n : n - m;
          if (diff <= lim && dist_now[n] <= lim) fuzzy = 1'b1;
        end
        if (fuzzy) q = Q_FUZZY;
      end
    end
    quality_due.push_back(q);
    clear_word_state();
  endfunction

  function automatic void push_req(input logic op, input logic [CHAR_W-1:0] ch,
                                   input logic fin);
    pending.push_back({op, ch, fin});
    reqs_queued++;
  endfunction

  // mostly a four-letter alphabet so that matches happen, sometimes any code unit
  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 3) != 0)
      return LETTER_BASE + CHAR_W'($urandom_range(0, 3));
    return CHAR_W'($urandom);
  endfunction

  // request driver: payload held until accepted, model fed at the accepting edge
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        score_char(on_wire);
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_wire     = pending.pop_front();
          in_valid   <= 1'b1;
          opcode     <= on_wire.op;
          character  <= on_wire.ch;
          final_char <= on_wire.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: every accepted quality against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (quality_due.size() == 0) begin
          $display("%0t: quality with nothing expected: expected none, got %0d",
                   $realtime, quality);
          mismatches++;
        end else begin
          if (quality !== quality_due[0]) begin
            $display("%0t: quality mismatch: expected %0d, got %0d",
                     $realtime, quality_due[0], quality);
            mismatches++;
          end
          if (quality_due[0] == Q_EXACT) exact_count++;
          if (quality_due[0] == Q_FUZZY) fuzzy_count++;
          void'(quality_due.pop_front());
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: too long without any handshake on either channel
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // all requests taken, all results in, then room for anything still in the row
  task automatic wait_drain();
    do @(posedge clk);
    while (reqs_taken < reqs_queued || quality_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, spare data bits of the typo write filled with noise
  task automatic write_regs(input logic [GAP_W-1:0] gaps, input logic [TYPO_W-1:0] typos);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GAPS;
    cfg_data  <= gaps;
    @(posedge clk);
    cfg_index <= REG_TYPOS;
    cfg_data  <= {junk[CFG_W-1:TYPO_W], typos};
    @(posedge clk);
    cfg_we    <= 1'b0;
    gaps_cfg  = gaps;
    typos_cfg = typos;
  endtask

  // a term then a few words built from it: substrings, spread-out letters, typos, noise
  task automatic mix_phase(input int target);
    logic [CHAR_W-1:0] term[$];
    logic [CHAR_W-1:0] word[$];
    logic [CHAR_W-1:0] tmp;
    int start, len, n, kind, j, idx, roll;
    bit complete;
    start = reqs_queued;
    while (reqs_queued - start < target) begin
      term.delete();
      roll = $urandom_range(0, 99);
      if (roll < 80)      len = $urandom_range(1, 6);
      else if (roll < 93) len = $urandom_range(7, MAX_TERM_DEF);
      else                len = $urandom_range(MAX_TERM_DEF + 1, MAX_TERM_DEF + 8);
      n = (len > MAX_TERM_DEF) ? MAX_TERM_DEF : len;
      for (j = 0; j < len; j++) term.push_back(pick_char());
      // now and then the term is left unfinished
      complete = ($urandom_range(0, 9) != 0);
      for (j = 0; j < len; j++) push_req(OP_TERM, term[j], complete && j == len - 1);

      repeat ($urandom_range(1, 4)) begin
        word.delete();
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1: begin
            // the term somewhere inside
            repeat ($urandom_range(0, 3)) word.push_back(pick_char());
            for (j = 0; j < n; j++) word.push_back(term[j]);
            repeat ($urandom_range(0, 3)) word.push_back(pick_char());
          end
          2, 3: begin
            // term letters in order with filler between them
            word.push_back(term[0]);
            for (j = 1; j < n; j++) begin
              if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(3, 40)) word.push_back(pick_char());
              else
                repeat ($urandom_range(0, 2)) word.push_back(pick_char());
              word.push_back(term[j]);
            end
            repeat ($urandom_range(0, 2)) word.push_back(pick_char());
          end
          4, 5, 6: begin
            // one or two edits: change, add, drop or swap neighbors
            for (j = 0; j < n; j++) word.push_back(term[j]);
            repeat ($urandom_range(1, 2)) begin
              if (word.size() == 0) word.push_back(pick_char());
              idx = $urandom_range(0, word.size() - 1);
              case ($urandom_range(0, 3))
                0: word[idx] = pick_char();
                1: word.insert(idx, pick_char());
                2: word.delete(idx);
                default: begin
                  if (idx + 1 < word.size()) begin
                    tmp         = word[idx];
                    word[idx]   = word[idx+1];
                    word[idx+1] = tmp;
                  end
                end
              endcase
            end
          end
          7, 8: repeat ($urandom_range(1, 8)) word.push_back(pick_char());
          default: begin
            // around the longest word the typo match accepts
            if ($urandom_range(0, 2) == 0)
              repeat ($urandom_range(LONGEST_WORD_DEF - 8, LONGEST_WORD_DEF + 8))
                word.push_back(pick_char());
            else
              repeat ($urandom_range(1, 8)) word.push_back(pick_char());
          end
        endcase
        if (word.size() == 0) word.push_back(pick_char());
        for (j = 0; j < word.size(); j++) begin
          // a stray term character abandons the word in progress
          if (j != 0 && $urandom_range(0, 99) < 2)
            push_req(OP_TERM, pick_char(), 1'($urandom_range(0, 1)));
          push_req(OP_WORD, word[j], j == word.size() - 1);
        end
      end
    end
  endtask

  initial begin : stimulus
    int p;
    term_len  = 0;
    term_done = 1'b0;
    gaps_cfg  = '0;
    typos_cfg = '0;
    for (p = 0; p < MAX_TERM_DEF; p++) term_chars[p] = '0;
    clear_word_state();
    send_idle_pct = 9;
    recv_idle_pct = 64;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed requests, registers still at reset values
    // word before any term: empty term gives none
    push_req(OP_WORD, LETTER_BASE, 1'b1);
    // term of the extreme code units, then a word holding it
    push_req(OP_TERM, 16'h0000, 1'b0);
    push_req(OP_TERM, 16'hFFFF, 1'b1);
    push_req(OP_WORD, 16'h1234, 1'b0);
    push_req(OP_WORD, 16'h0000, 1'b0);
    push_req(OP_WORD, 16'hFFFF, 1'b1);
    // same letters with one between them: no gap allowed, so none
    push_req(OP_WORD, 16'h0000, 1'b0);
    push_req(OP_WORD, 16'h5555, 1'b0);
    push_req(OP_WORD, 16'hFFFF, 1'b1);
    // unfinished term: even an identical word gives none
    push_req(OP_TERM, LETTER_BASE, 1'b0);
    push_req(OP_TERM, LETTER_BASE + 16'd1, 1'b0);
    push_req(OP_TERM, LETTER_BASE + 16'd2, 1'b0);
    push_req(OP_WORD, LETTER_BASE, 1'b0);
    push_req(OP_WORD, LETTER_BASE + 16'd1, 1'b0);
    push_req(OP_WORD, LETTER_BASE + 16'd2, 1'b1);
    // finishing the term extends it, then the full term matches
    push_req(OP_TERM, LETTER_BASE + 16'd3, 1'b1);
    push_req(OP_WORD, LETTER_BASE, 1'b0);
    push_req(OP_WORD, LETTER_BASE + 16'd1, 1'b0);
    push_req(OP_WORD, LETTER_BASE + 16'd2, 1'b0);
    push_req(OP_WORD, LETTER_BASE + 16'd3, 1'b1);
    // term character mid-word drops the word and starts a new term
    push_req(OP_WORD, LETTER_BASE, 1'b0);
    push_req(OP_TERM, 16'h8001, 1'b1);
    push_req(OP_WORD, 16'h8001, 1'b1);
    wait_drain();

    // random phases across register settings and idling patterns
    for (p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_idle_pct = 9;
        recv_idle_pct = 64;
      end else if (p < 8) begin
        send_idle_pct = 64;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p % 3)
        0:       write_regs('0, TYPO_W'(p % 4));
        1:       write_regs('1, TYPO_W'(p % 4));
        default: write_regs(GAP_W'($urandom_range(0, 63)), TYPO_W'(p % 4));
      endcase
      mix_phase(12);
      wait_drain();
    end

    $display("covered %0d requests: directed corner words, then 12 register settings",
             reqs_taken);
    $display("checked %0d qualities: %0d exact, %0d fuzzy, %0d mismatches",
             results_seen, exact_count, fuzzy_count, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
